// File: sv/sum_of_two_primes_test_assert.svh
// Assertion macros shared by the two-prime sum test block.
`ifndef SUM_OF_TWO_PRIMES_TEST_ASSERT_SVH
`define SUM_OF_TWO_PRIMES_TEST_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define STPT_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define STPT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/stpt_pkg.sv
// Widths, constants and controller/datapath types of the two-prime sum test.
package stpt_pkg;

   localparam int VALUE_WIDTH = 40;
   localparam int SUM_WIDTH   = VALUE_WIDTH + 1;
   localparam int DIV_WIDTH   = (SUM_WIDTH + 1) / 2 + 1;
   localparam int SQ_WIDTH    = SUM_WIDTH + 1;
   localparam int CNT_WIDTH   = $clog2(SUM_WIDTH + 1);

   localparam int SMALLEST_YES_SUM  = 4;
   localparam int FIRST_ODD_DIVISOR = 3;
   localparam int DIVISOR_STEP      = 2;

   typedef struct packed {
      logic load_sum;
      logic load_v;
      logic start_div;
      logic step_div;
      logic next_div;
   } stpt_cmd_type;

   typedef struct packed {
      logic sum_small;
      logic sum_even;
      logic sq_le_v;
      logic div_done;
      logic rem_zero;
   } stpt_stat_type;

endpackage

// File: sv/stpt_if.sv
// Valid/ready channel interfaces for operand and result words.
interface stpt_req_if import stpt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] first_value;
   logic [VALUE_WIDTH-1:0] second_value;

   modport source (output valid, first_value, second_value, input ready);
   modport sink (input valid, first_value, second_value, output ready);
endinterface

interface stpt_rsp_if import stpt_pkg::*; ();
   logic valid;
   logic ready;
   logic is_two_prime_sum;

   modport source (output valid, is_two_prime_sum, input ready);
   modport sink (input valid, is_two_prime_sum, output ready);
endinterface

// File: sv/stpt_dp.sv
// Datapath: sum, odd trial divisor with running square, bit-serial remainder.
module stpt_dp import stpt_pkg::*; (
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] first_value,
   input  logic [VALUE_WIDTH-1:0] second_value,
   input  stpt_cmd_type           cmd,
   output stpt_stat_type          stat
);

   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [SUM_WIDTH-1:0] v_ff, v_in;
   logic [SUM_WIDTH-1:0] q_ff, q_in;
   logic [DIV_WIDTH-1:0] d_ff, d_in;
   logic [SQ_WIDTH-1:0]  sq_ff, sq_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_WIDTH:0]   shifted;
   logic [DIV_WIDTH:0]   trial;

   // Shift the next dividend bit into the partial remainder, subtract if it fits
   assign shifted = {rem_ff, q_ff[SUM_WIDTH-1]};
   assign trial   = shifted - {1'b0, d_ff};

   always_comb begin
      sum_in = sum_ff;
      v_in   = v_ff;
      q_in   = q_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load_sum) begin
         sum_in = SUM_WIDTH'(first_value) + SUM_WIDTH'(second_value);
      end
      // Start primality test of s - 2 at the first odd divisor
      if (cmd.load_v) begin
         v_in  = sum_ff - SUM_WIDTH'(DIVISOR_STEP);
         d_in  = DIV_WIDTH'(FIRST_ODD_DIVISOR);
         sq_in = SQ_WIDTH'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
      end
      if (cmd.start_div) begin
         q_in   = v_ff;
         rem_in = '0;
         cnt_in = CNT_WIDTH'(SUM_WIDTH);
      end
      // A clear borrow bit means the divisor fit
      if (cmd.step_div) begin
         q_in   = {q_ff[SUM_WIDTH-2:0], 1'b0};
         rem_in = (!trial[DIV_WIDTH]) ? trial[DIV_WIDTH-1:0]
                                      : shifted[DIV_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
      // Advance to the next odd divisor: (d+2)^2 = d^2 + 4(d+1)
      if (cmd.next_div) begin
         d_in  = d_ff + DIV_WIDTH'(DIVISOR_STEP);
         sq_in = sq_ff + SQ_WIDTH'({d_ff + DIV_WIDTH'(1), 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      v_ff   <= v_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // Report status to the controller
   assign stat.sum_small = sum_ff < SUM_WIDTH'(SMALLEST_YES_SUM);
   assign stat.sum_even  = ~sum_ff[0];
   assign stat.sq_le_v   = sq_ff <= SQ_WIDTH'(v_ff);
   assign stat.div_done  = cnt_ff == '0;
   assign stat.rem_zero  = rem_ff == '0;

endmodule

// File: sv/stpt_ctrl.sv
// Controller: sequences classification, trial division and result hand-off.
module stpt_ctrl import stpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_bit,
   input  stpt_stat_type stat,
   output stpt_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CLASSIFY,
      CHECK,
      DIVIDE,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ans_ff, ans_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_bit_ff, rsp_bit_in;

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bit   = rsp_bit_ff;

   always_comb begin
      state_in     = state_ff;
      ans_in       = ans_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      cmd          = '0;
      // Drop the result word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_sum = 1'b1;
               state_in     = CLASSIFY;
            end
         end
         CLASSIFY: begin
            if (stat.sum_small) begin
               ans_in   = 1'b0;
               state_in = FINISH;
            end else if (stat.sum_even) begin
               ans_in   = 1'b1;
               state_in = FINISH;
            end else begin
               cmd.load_v = 1'b1;
               state_in   = CHECK;
            end
         end
         CHECK: begin
            if (!stat.sq_le_v) begin
               ans_in   = 1'b1;
               state_in = FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = DIVIDE;
            end
         end
         DIVIDE: begin
            if (!stat.div_done) begin
               cmd.step_div = 1'b1;
            end else if (stat.rem_zero) begin
               ans_in   = 1'b0;
               state_in = FINISH;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = CHECK;
            end
         end
         FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = ans_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ans_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_bit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ans_ff       <= ans_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_bit_ff   <= rsp_bit_in;
      end
   end

endmodule

// File: sv/sum_of_two_primes_test.sv
// Top level of the two-prime sum test: controller, datapath and assertions.
//
//   channel   dir   word contents
//   req_if    in    first_value[VALUE_WIDTH], second_value[VALUE_WIDTH]
//   rsp_if    out   is_two_prime_sum
//
// Sums below 4 and even sums skip trial division and go from CLASSIFY to FINISH.
// Odd sums test s - 2 by odd trial divisors d with d*d <= s - 2; each divisor
// takes one check, SUM_WIDTH remainder steps and one decision.
// One item is in work at a time; the next is taken while a result waits.
// Synchronous active-high reset clears the controller and the output valid.
`include "sum_of_two_primes_test_assert.svh"

module sum_of_two_primes_test import stpt_pkg::*; (
   input logic       clock,
   input logic       reset,
   stpt_req_if.sink  req_if,
   stpt_rsp_if.source rsp_if
);

   stpt_cmd_type  dp_cmd;
   stpt_stat_type dp_stat;
   logic          req_take;
   logic          rem_left;

   stpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_bit   (rsp_if.is_two_prime_sum),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   stpt_dp u_dp (
      .clock        (clock),
      .first_value  (req_if.first_value),
      .second_value (req_if.second_value),
      .cmd          (dp_cmd),
      .stat         (dp_stat)
   );

   // Shorthand terms for the checks below
   assign req_take = req_if.valid && req_if.ready;
   assign rem_left = dp_stat.div_done && !dp_stat.rem_zero;

   `STPT_ASSERT_SAME(a_load_on_accept, clock, reset, dp_cmd.load_sum, req_take, "stray load")
   `STPT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, !req_if.ready, "ready held")
   `STPT_ASSERT_SAME(a_step_not_done, clock, reset, dp_cmd.step_div, !dp_stat.div_done, "overstep")
   `STPT_ASSERT_SAME(a_next_on_nonzero, clock, reset, dp_cmd.next_div, rem_left, "bad advance")

endmodule
